>>> src/isc_pkg.sv
// Shared types, codes and modular helpers of the interleaved subsequence counter.
// No dependencies; the top, the sequencer and the datapath import this package.
`default_nettype none
package isc_pkg;

  localparam int CW = 14;
  localparam logic [CW-1:0] WAY_MOD = 14'd10007;

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_LOAD_C  = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  localparam logic [1:0] CFG_LENGTH_A = 2'd0;
  localparam logic [1:0] CFG_LENGTH_B = 2'd1;
  localparam logic [1:0] CFG_LENGTH_C = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_LWAIT, S_LSTART, S_CREAD, S_CCALC, S_FREAD, S_FWAIT
  } state_t;

  typedef struct packed {
    logic load_we;
    logic start;
    logic step;
    logic rewind;
    logic next_layer;
    logic latch_want;
    logic init_we;
    logic calc_we;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cell_last;
    logic k_zero;
    logic k_one;
  } status_t;

  function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, WAY_MOD}) s = s - {1'b0, WAY_MOD};
    return s[CW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/isc_in_if.sv
// Request channel: load or compute beats into the counter.
// Uses nothing else.
`default_nettype none
interface isc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] position;
  logic [7:0] symbol;
  modport source (output valid, req_type, position, symbol, input ready);
  modport sink (input valid, req_type, position, symbol, output ready);
endinterface
`default_nettype wire

>>> src/isc_out_if.sv
// Result channel: one way count beat per compute request.
// Uses nothing else.
`default_nettype none
interface isc_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] way_count;
  modport source (output valid, way_count, input ready);
  modport sink (input valid, way_count, output ready);
endinterface
`default_nettype wire

>>> src/interleaved_subsequence_counter_top.sv
// Load beats are written into the symbol stores as they are taken. A compute holds the input
// for its whole run, counting its own beat, with clamped lengths: one init write per cell,
// then for each layer of C a setup (LWAIT, LSTART) and a sweep that reads the stores, then
// sums and writes back each cell, then a readout (FREAD, FWAIT); a stalled result holds the
// readout until the output slot frees. One compute is worked at a time; the result waits in an
// output register while the next beat is taken.
// Reset (synchronous, rst_n low) clears the lengths, the sequencer and the result valid;
// the symbol and layer stores are not cleared.
`default_nettype none
module interleaved_subsequence_counter_top #(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  isc_in_if.sink          in_ch,
  isc_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);
  import isc_pkg::*;

  cmd_t    cmd;
  status_t stat;

  isc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_req(in_ch.req_type), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  isc_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk, .rst_n,
    .in_req(in_ch.req_type), .in_position(in_ch.position), .in_symbol(in_ch.symbol),
    .cfg_we, .cfg_index, .cfg_data,
    .cmd, .stat, .way_count(out_ch.way_count)
  );
endmodule
`default_nettype wire

>>> src/isc_ram.sv
// Generic one-write, one-read RAM with registered read data.
// Uses nothing else.
`default_nettype none
module isc_ram #(
  parameter int W = 8,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/isc_ctrl.sv
// Sequencer of the counter: steps the init pass, the per-layer cell sweep and the readout.
// Depends on isc_pkg.
`default_nettype none
module isc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_req,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire isc_pkg::status_t stat,
  output isc_pkg::cmd_t         cmd
);
  import isc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc, slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (acc && in_req == REQ_COMPUTE) state_nxt = S_INIT;
      S_INIT:   if (stat.cell_last) state_nxt = stat.k_zero ? S_FREAD : S_LWAIT;
      S_LWAIT:  state_nxt = S_LSTART;
      S_LSTART: state_nxt = S_CREAD;
      S_CREAD:  state_nxt = S_CCALC;
      S_CCALC: begin
        if (stat.cell_last) state_nxt = stat.k_one ? S_FREAD : S_LWAIT;
        else state_nxt = S_CREAD;
      end
      S_FREAD:  state_nxt = S_FWAIT;
      S_FWAIT:  if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_we = acc && in_req != REQ_COMPUTE;
        cmd.start   = acc && in_req == REQ_COMPUTE;
      end
      S_INIT: begin
        cmd.init_we = 1'b1;
        cmd.step    = !stat.cell_last;
        cmd.rewind  = stat.cell_last;
      end
      S_LSTART: cmd.latch_want = 1'b1;
      S_CCALC: begin
        cmd.calc_we    = 1'b1;
        cmd.step       = !stat.cell_last;
        cmd.rewind     = stat.cell_last;
        cmd.next_layer = stat.cell_last;
      end
      S_FREAD: cmd.fin = 1'b1;
      S_FWAIT: begin
        cmd.fin      = 1'b1;
        cmd.out_load = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_cread_calc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CREAD |=> state_r == S_CCALC) else $error("read not followed by calc");
  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == S_INIT) else $error("compute did not start init");
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && out_valid_r && !out_ready)) else $error("result overwritten");
  a_layer_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CCALC |-> !stat.k_zero) else $error("cell sweep with no layer left");
`endif
endmodule
`default_nettype wire

>>> src/isc_dp.sv
// Datapath: symbol stores, two-copy layer table, column run sums, counters, result register.
// Depends on isc_pkg and isc_ram.
`default_nettype none
module isc_dp #(
  parameter int MAX_LEN = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     in_req,
  input  wire logic [5:0]     in_position,
  input  wire logic [7:0]     in_symbol,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [6:0]     cfg_data,
  input  wire isc_pkg::cmd_t  cmd,
  output isc_pkg::status_t    stat,
  output logic [13:0]         way_count
);
  import isc_pkg::*;

  localparam int SIDE = MAX_LEN + 1;
  localparam int SS   = SIDE * SIDE;
  localparam int LD   = 2 * SS;
  localparam int LW   = $clog2(SIDE);
  localparam int PW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int AW   = $clog2(LD);

  logic [6:0] len_a_r, len_b_r, len_c_r;
  logic [LW-1:0] la, lb, lc;
  logic [LW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic src_r, src_nxt;
  logic [7:0] want_r;
  logic [CW-1:0] row_r, out_r;

  function automatic logic [LW-1:0] clamp(input logic [6:0] v);
    logic [15:0] w;
    w = {9'd0, v};
    if (w > 16'(MAX_LEN)) w = 16'(MAX_LEN);
    return w[LW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic layer, input logic [LW-1:0] r,
                                              input logic [LW-1:0] c);
    logic [31:0] a;
    a = (layer ? 32'(SS) : 32'd0) + 32'(r) * 32'(SIDE) + 32'(c);
    return a[AW-1:0];
  endfunction

  assign la = clamp(len_a_r);
  assign lb = clamp(len_b_r);
  assign lc = clamp(len_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= '0;
      len_b_r <= '0;
      len_c_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LENGTH_A) len_a_r <= cfg_data;
      if (cfg_index == CFG_LENGTH_B) len_b_r <= cfg_data;
      if (cfg_index == CFG_LENGTH_C) len_c_r <= cfg_data;
    end
  end

  // symbol loads; positions past the store are dropped
  logic [15:0] pos_w;
  logic pos_ok;
  logic [PW-1:0] pos_ix;
  assign pos_w  = {10'd0, in_position};
  assign pos_ok = pos_w < 16'(MAX_LEN);
  assign pos_ix = pos_w[PW-1:0];

  logic [7:0] a_q, b_q, c_q;
  logic [15:0] ia_w, jb_w, kc_w;
  assign ia_w = 16'(i_r);
  assign jb_w = 16'(j_r);
  assign kc_w = 16'(k_r) - 16'd1;

  isc_ram #(.W(8), .D(MAX_LEN)) u_text_a (.clk, .we(cmd.load_we && pos_ok && in_req == REQ_LOAD_A),
    .waddr(pos_ix), .wdata(in_symbol), .raddr(ia_w[PW-1:0]), .rdata(a_q));
  isc_ram #(.W(8), .D(MAX_LEN)) u_text_b (.clk, .we(cmd.load_we && pos_ok && in_req == REQ_LOAD_B),
    .waddr(pos_ix), .wdata(in_symbol), .raddr(jb_w[PW-1:0]), .rdata(b_q));
  isc_ram #(.W(8), .D(MAX_LEN)) u_pat_c (.clk, .we(cmd.load_we && pos_ok && in_req == REQ_LOAD_C),
    .waddr(pos_ix), .wdata(in_symbol), .raddr(kc_w[PW-1:0]), .rdata(c_q));

  // layer table, kept twice so both neighbors are read in the same cycle
  logic i_in, j_in;
  logic [LW-1:0] i_up, j_up;
  logic [AW-1:0] l_waddr, l_raddr0, l_raddr1;
  logic [CW-1:0] l_wdata, q0, q1, col_q, cur, run_a, run_b;
  logic l_we, cond_a, cond_b;

  assign i_in = i_r < la;
  assign j_in = j_r < lb;
  assign i_up = i_in ? i_r + 1'b1 : i_r;
  assign j_up = j_in ? j_r + 1'b1 : j_r;

  assign l_we     = cmd.init_we || cmd.calc_we;
  assign l_waddr  = cell_addr(cmd.init_we ? src_r : ~src_r, i_r, j_r);
  assign l_wdata  = cmd.init_we ? CW'(1) : cur;
  assign l_raddr0 = cmd.fin ? cell_addr(src_r, '0, '0) : cell_addr(src_r, i_up, j_r);
  assign l_raddr1 = cell_addr(src_r, i_r, j_up);

  isc_ram #(.W(CW), .D(LD)) u_layer0 (.clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr0), .rdata(q0));
  isc_ram #(.W(CW), .D(LD)) u_layer1 (.clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr1), .rdata(q1));

  // column run sums; the first row of a layer starts them at zero
  isc_ram #(.W(CW), .D(SIDE)) u_col (.clk, .we(cmd.calc_we), .waddr(j_r), .wdata(run_a),
    .raddr(j_r), .rdata(col_q));

  assign cond_a = i_in && a_q == want_r;
  assign cond_b = j_in && b_q == want_r;
  assign run_a  = mod_add((i_r == la) ? '0 : col_q, cond_a ? q0 : '0);
  assign run_b  = mod_add((j_r == lb) ? '0 : row_r, cond_b ? q1 : '0);
  assign cur    = mod_add(run_a, run_b);

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    src_nxt = src_r;
    if (cmd.step) begin
      if (j_r == '0) begin
        j_nxt = lb;
        i_nxt = i_r - 1'b1;
      end else begin
        j_nxt = j_r - 1'b1;
      end
    end
    if (cmd.rewind) begin
      i_nxt = la;
      j_nxt = lb;
    end
    if (cmd.next_layer) begin
      k_nxt   = k_r - 1'b1;
      src_nxt = ~src_r;
    end
    if (cmd.start) begin
      i_nxt   = la;
      j_nxt   = lb;
      k_nxt   = lc;
      src_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r   <= '0;
      j_r   <= '0;
      k_r   <= '0;
      src_r <= 1'b0;
    end else begin
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      k_r   <= k_nxt;
      src_r <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_want) want_r <= c_q;
    if (cmd.calc_we) row_r <= run_b;
    if (cmd.out_load) out_r <= q0;
  end

  assign stat.cell_last = (i_r == '0) && (j_r == '0);
  assign stat.k_zero    = (k_r == '0);
  assign stat.k_one     = (k_r == LW'(1));
  assign way_count      = out_r;
endmodule
`default_nettype wire
